// ===== rtl/lstk_pkg.sv =====
// Shared types and codes for the LIFO stack with indexed read and reversal.
// Holds operation and status codes and the fixed stream field widths.
// No dependencies.
package lstk_pkg;

   localparam int OP_W        = 3;
   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 8;
   localparam int DATA_OUT_W  = 32;
   localparam int STATUS_W    = 2;
   localparam int FILL_W      = 9;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_PUSH    = 3'd0;
   localparam op_type OP_POP     = 3'd1;
   localparam op_type OP_PEEK    = 3'd2;
   localparam op_type OP_READ    = 3'd3;
   localparam op_type OP_REVERSE = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_RANGE = 2'd2;
   localparam status_type ST_FULL  = 2'd3;

endpackage

// ===== rtl/lstk_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while the read enable is low. No dependencies.
module lstk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lifo_stack_with_index_and_reverse.sv =====
// LIFO stack top level: request sequencer, swap walker and result register.
// Depends on lstk_pkg and lstk_ram.
// Push, pop, peek, read and undefined ops pass from accept to S_EMIT, which loads the result
// register once it is free. Reverse of n > 1 elements walks swaps: each swap is two reads and two
// writes through the single read and single write port of the element RAM.
// A new request is taken only after the last result is loaded; req_tready is low while busy.
// Reset clears fill count, sequencer and rsp_tvalid; stored elements are left as they are.
module lifo_stack_with_index_and_reverse #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lstk_pkg::REQ_TDATA_W-1:0] req_tdata,  // value[31:0], index[39:32]
   input  logic [lstk_pkg::OP_W-1:0]        req_tuser,  // op[2:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lstk_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // read_data[31:0], fill_count[40:32]
   output logic [lstk_pkg::STATUS_W-1:0]    rsp_tuser   // status[1:0]
);
   import lstk_pkg::*;

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int XW  = (CW > INDEX_W) ? CW : INDEX_W;
   localparam int VW  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int FXW = (CW > FILL_W) ? CW : FILL_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_COUNT  = CW'(1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EMIT     = 3'd1;
   localparam logic [2:0] S_RV_RD_LO = 3'd2;
   localparam logic [2:0] S_RV_RD_HI = 3'd3;
   localparam logic [2:0] S_RV_WR_HI = 3'd4;
   localparam logic [2:0] S_RV_WR_LO = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic [DATA_WIDTH-1:0] tmp_ff, tmp_in;
   status_type            pend_status_ff, pend_status_in;
   logic                  use_rd_ff, use_rd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_OUT_W-1:0] rsp_data_ff, rsp_data_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [FILL_W-1:0]     rsp_count_ff, rsp_count_in;

   op_type                op;
   logic [VALUE_W-1:0]    value;
   logic [INDEX_W-1:0]    index;
   logic                  accept;
   logic [VW-1:0]         value_ext, rd_ext;
   logic [XW-1:0]         index_ext, count_ext;
   logic [FXW-1:0]        fill_ext;
   logic [CW-1:0]         count_m1;
   logic [AW-1:0]         lo_nx, hi_nx;
   logic                  is_full, is_empty;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;

   lstk_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign op         = req_tuser;
   assign value      = req_tdata[VALUE_W-1:0];
   assign index      = req_tdata[VALUE_W+INDEX_W-1:VALUE_W];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign value_ext = VW'(value);
   assign rd_ext    = VW'(rd_data);
   assign index_ext = XW'(index);
   assign count_ext = XW'(count_ff);
   assign fill_ext  = FXW'(count_ff);
   assign count_m1  = count_ff - ONE_COUNT;
   assign lo_nx     = lo_ff + 1'b1;
   assign hi_nx     = hi_ff - 1'b1;
   assign is_full   = (count_ff == FULL_COUNT);
   assign is_empty  = (count_ff == '0);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      tmp_in         = tmp_ff;
      pend_status_in = pend_status_ff;
      use_rd_in      = use_rd_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      wr_en          = 1'b0;
      wr_addr        = count_ff[AW-1:0];
      wr_data        = value_ext[DATA_WIDTH-1:0];
      rd_en          = 1'b0;
      rd_addr        = count_m1[AW-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_status_in = ST_OK;
               use_rd_in      = 1'b0;
               state_in       = S_EMIT;
               case (op)
                  OP_PUSH: begin
                     if (is_full) begin
                        pend_status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + ONE_COUNT;
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        pend_status_in = ST_EMPTY;
                     end else begin
                        rd_en     = 1'b1;
                        use_rd_in = 1'b1;
                        count_in  = count_m1;
                     end
                  end
                  OP_PEEK: begin
                     if (is_empty) begin
                        pend_status_in = ST_EMPTY;
                     end else begin
                        rd_en     = 1'b1;
                        use_rd_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (index_ext >= count_ext) begin
                        pend_status_in = ST_RANGE;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = index_ext[AW-1:0];
                        use_rd_in = 1'b1;
                     end
                  end
                  OP_REVERSE: begin
                     if (count_ff > ONE_COUNT) begin
                        lo_in    = '0;
                        hi_in    = count_m1[AW-1:0];
                        state_in = S_RV_RD_LO;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RV_RD_LO: begin
            rd_en    = 1'b1;
            rd_addr  = lo_ff;
            state_in = S_RV_RD_HI;
         end
         S_RV_RD_HI: begin
            rd_en    = 1'b1;
            rd_addr  = hi_ff;
            tmp_in   = rd_data;
            state_in = S_RV_WR_HI;
         end
         S_RV_WR_HI: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff;
            wr_data  = tmp_ff;
            state_in = S_RV_WR_LO;
         end
         S_RV_WR_LO: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = rd_data;
            lo_in   = lo_nx;
            hi_in   = hi_nx;
            if (lo_nx < hi_nx) begin
               state_in = S_RV_RD_LO;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = use_rd_ff ? rd_ext[DATA_OUT_W-1:0] : '0;
               rsp_status_in = pend_status_ff;
               rsp_count_in  = fill_ext[FILL_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      tmp_ff         <= tmp_in;
      pend_status_ff <= pend_status_in;
      use_rd_ff      <= use_rd_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_count_ff, rsp_data_ff});
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== rtl/lstk_checker.sv =====
// Port-level checker for the LIFO stack, attached to the top level by bind.
// Depends on lstk_pkg.
module lstk_checker #(
   parameter int DEPTH = 256
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lstk_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [lstk_pkg::STATUS_W-1:0]    rsp_tuser
);
   import lstk_pkg::*;

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response word changed");

   // drop ready in the cycle after each accepted word
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted on back-to-back cycles");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_EMPTY |->
         rsp_tdata[DATA_OUT_W-1:0] == '0 && rsp_tdata[DATA_OUT_W+FILL_W-1:DATA_OUT_W] == '0)
      else $error("empty status with data or non-zero fill count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_RANGE || rsp_tuser == ST_FULL) |->
         rsp_tdata[DATA_OUT_W-1:0] == '0)
      else $error("error status with non-zero read data");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL |->
         rsp_tdata[DATA_OUT_W+FILL_W-1:DATA_OUT_W] == FILL_W'(DEPTH))
      else $error("full status below depth");

endmodule

bind lifo_stack_with_index_and_reverse lstk_checker #(
   .DEPTH (DEPTH)
) u_lstk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
